### rtl/dasp_pkg.sv
// shared types and constants of the add/subtract line evaluator
`default_nettype none

package dasp_pkg;

  localparam int NUMBER_BITS = 31;
  // ten times a number plus a digit needs four more bits
  localparam int ACC_BITS    = NUMBER_BITS + 4;
  localparam int VALUE_BITS  = 33;
  localparam int SUM_BITS    = (NUMBER_BITS + 1 > VALUE_BITS) ? NUMBER_BITS + 1 : VALUE_BITS;
  localparam int CHAR_BITS   = 8;
  localparam int IN_DATA_BITS  = 8;
  localparam int OUT_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    TOK_BLANK,
    TOK_DIGIT,
    TOK_PLUS,
    TOK_MINUS,
    TOK_OTHER,
    TOK_EOL
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
  } token_t;

endpackage

`default_nettype wire

### rtl/dasp_front.sv
// front end: classifies each incoming byte or end-of-line mark into a token
`default_nettype none

module dasp_front (
  input  wire logic [dasp_pkg::CHAR_BITS-1:0] char_i,
  input  wire logic                           eol_i,
  output dasp_pkg::token_t                    token_o
);

  always_comb begin
    token_o.digit = char_i[3:0];  // low nibble of '0'..'9' is the digit
    if (eol_i) begin
      token_o.kind = dasp_pkg::TOK_EOL;
    end else begin
      case (char_i) inside
        [dasp_pkg::CHAR_TAB:dasp_pkg::CHAR_CR], dasp_pkg::CHAR_SPACE: begin
          token_o.kind = dasp_pkg::TOK_BLANK;
        end
        [dasp_pkg::CHAR_ZERO:dasp_pkg::CHAR_NINE]: begin
          token_o.kind = dasp_pkg::TOK_DIGIT;
        end
        dasp_pkg::CHAR_PLUS: begin
          token_o.kind = dasp_pkg::TOK_PLUS;
        end
        dasp_pkg::CHAR_MINUS: begin
          token_o.kind = dasp_pkg::TOK_MINUS;
        end
        default: begin
          token_o.kind = dasp_pkg::TOK_OTHER;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/dasp_queue.sv
// short token queue between the front end and the evaluator
`default_nettype none

module dasp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dasp_pkg::token_t  push_token_i,
  output logic                   full_o,
  output logic                   valid_o,
  output dasp_pkg::token_t       token_o,
  input  wire logic              pop_i
);

  dasp_pkg::token_t mem_q [dasp_pkg::QUEUE_DEPTH];
  logic [dasp_pkg::QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [dasp_pkg::QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [dasp_pkg::QCNT_BITS-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == dasp_pkg::QCNT_BITS'(dasp_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign token_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == dasp_pkg::QPTR_BITS'(dasp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == dasp_pkg::QPTR_BITS'(dasp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_token_i;
    end
  end

endmodule

`default_nettype wire

### rtl/dasp_back.sv
// evaluator: token order, number accumulation and the result register
`default_nettype none

module dasp_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            tok_valid_i,
  input  wire dasp_pkg::token_t                token_i,
  output logic                                 tok_pop_o,
  output logic                                 res_valid_o,
  output logic [dasp_pkg::VALUE_BITS-1:0]      res_value_o,
  output logic                                 res_status_o,
  input  wire logic                            res_ready_i
);

  localparam logic [2:0] PH_FIRST     = 3'd0;
  localparam logic [2:0] PH_LEFT      = 3'd1;
  localparam logic [2:0] PH_OPERATOR  = 3'd2;
  localparam logic [2:0] PH_SECOND    = 3'd3;
  localparam logic [2:0] PH_RIGHT     = 3'd4;
  localparam logic [2:0] PH_LOOKAHEAD = 3'd5;
  localparam logic [2:0] PH_DONE      = 3'd6;
  localparam logic [2:0] PH_ERROR     = 3'd7;

  localparam int N = dasp_pkg::NUMBER_BITS;
  localparam int A = dasp_pkg::ACC_BITS;
  localparam int S = dasp_pkg::SUM_BITS;

  logic [2:0]   phase_q, phase_d;
  logic [N-1:0] left_q, left_d;
  logic [N-1:0] right_q, right_d;
  logic         minus_q, minus_d;

  logic         out_valid_q, out_valid_d;
  logic [dasp_pkg::VALUE_BITS-1:0] out_value_q, out_value_d;
  logic         out_status_q, out_status_d;

  logic         out_free, take, is_eol;
  logic [N-1:0] acc_src, acc_new;
  logic [A-1:0] acc_ext, prod;
  logic [S-1:0] left_ext, right_ext, sum;

  assign out_free  = !out_valid_q || res_ready_i;
  assign is_eol    = (token_i.kind == dasp_pkg::TOK_EOL);
  // an end-of-line token waits for room in the result register
  assign take      = tok_valid_i && (!is_eol || out_free);
  assign tok_pop_o = take;

  // one shared times-ten-plus-digit unit; saturates when the result overflows
  always_comb begin
    case (phase_q)
      PH_LEFT:  acc_src = left_q;
      PH_RIGHT: acc_src = right_q;
      default:  acc_src = '0;
    endcase
    acc_ext = {{(A-N){1'b0}}, acc_src};
    prod    = (acc_ext << 3) + (acc_ext << 1) + {{(A-4){1'b0}}, token_i.digit};
    acc_new = (|prod[A-1:N]) ? {N{1'b1}} : prod[N-1:0];
  end

  assign left_ext  = {{(S-N){1'b0}}, left_q};
  assign right_ext = {{(S-N){1'b0}}, right_q};
  assign sum       = minus_q ? left_ext - right_ext : left_ext + right_ext;

  always_comb begin
    phase_d      = phase_q;
    left_d       = left_q;
    right_d      = right_q;
    minus_d      = minus_q;
    out_valid_d  = out_valid_q && !res_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    if (take) begin
      if (is_eol) begin
        out_valid_d = 1'b1;
        if (phase_q inside {PH_RIGHT, PH_LOOKAHEAD, PH_DONE}) begin
          out_value_d  = sum[dasp_pkg::VALUE_BITS-1:0];
          out_status_d = 1'b0;
        end else begin
          out_value_d  = '0;
          out_status_d = 1'b1;
        end
        phase_d = PH_FIRST;
        left_d  = '0;
        right_d = '0;
        minus_d = 1'b0;
      end else begin
        case (phase_q)
          PH_FIRST: begin
            if (token_i.kind == dasp_pkg::TOK_DIGIT) begin
              left_d  = acc_new;
              phase_d = PH_LEFT;
            end else if (token_i.kind != dasp_pkg::TOK_BLANK) begin
              phase_d = PH_ERROR;
            end
          end
          PH_LEFT: begin
            case (token_i.kind)
              dasp_pkg::TOK_DIGIT: left_d = acc_new;
              dasp_pkg::TOK_BLANK: phase_d = PH_OPERATOR;
              dasp_pkg::TOK_PLUS, dasp_pkg::TOK_MINUS: begin
                minus_d = (token_i.kind == dasp_pkg::TOK_MINUS);
                phase_d = PH_SECOND;
              end
              default: phase_d = PH_ERROR;
            endcase
          end
          PH_OPERATOR: begin
            case (token_i.kind)
              dasp_pkg::TOK_BLANK: ;
              dasp_pkg::TOK_PLUS, dasp_pkg::TOK_MINUS: begin
                minus_d = (token_i.kind == dasp_pkg::TOK_MINUS);
                phase_d = PH_SECOND;
              end
              default: phase_d = PH_ERROR;
            endcase
          end
          PH_SECOND: begin
            if (token_i.kind == dasp_pkg::TOK_DIGIT) begin
              right_d = acc_new;
              phase_d = PH_RIGHT;
            end else if (token_i.kind != dasp_pkg::TOK_BLANK) begin
              phase_d = PH_ERROR;
            end
          end
          PH_RIGHT: begin
            case (token_i.kind)
              dasp_pkg::TOK_DIGIT: right_d = acc_new;
              dasp_pkg::TOK_BLANK: phase_d = PH_LOOKAHEAD;
              dasp_pkg::TOK_PLUS, dasp_pkg::TOK_MINUS: phase_d = PH_DONE;
              default: phase_d = PH_ERROR;
            endcase
          end
          PH_LOOKAHEAD: begin
            case (token_i.kind)
              dasp_pkg::TOK_BLANK: ;
              dasp_pkg::TOK_DIGIT, dasp_pkg::TOK_PLUS, dasp_pkg::TOK_MINUS: begin
                phase_d = PH_DONE;
              end
              default: phase_d = PH_ERROR;
            endcase
          end
          default: ;  // done and error hold until end of line
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      left_q      <= '0;
      right_q     <= '0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      left_q      <= left_d;
      right_q     <= right_d;
      minus_q     <= minus_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign res_valid_o  = out_valid_q;
  assign res_value_o  = out_value_q;
  assign res_status_o = out_status_q;

endmodule

`default_nettype wire

### rtl/decimal_add_sub_expression_parser.sv
// top level of the add/subtract line evaluator
//
// channel   dir  tdata                      tuser       tlast
// s_axis    in   [7:0] character            -           end of line
// m_axis    out  [32:0] value (signed)      [0] status  -
//
// one byte or end-of-line mark per cycle while the queue is not full; the
// evaluator updates its state once per token. a result reaches the output
// register in the cycle after the evaluator takes its end-of-line token;
// from the input it passes through the queue and then the output register.
// reset clears the queue, the evaluator state and the output valid flag.
// a stalled output holds the evaluator only on end of line; other tokens keep
// flowing, and the two-entry queue absorbs the ready path.
`default_nettype none

module decimal_add_sub_expression_parser (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [dasp_pkg::IN_DATA_BITS-1:0]   s_axis_tdata_i,  // [7:0] character
  input  wire logic                                s_axis_tlast_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic [dasp_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata_o,  // [32:0] value, rest zero
  output logic                                     m_axis_tuser_o   // [0] status
);

  dasp_pkg::token_t in_token, q_token;
  logic q_full, q_valid, q_pop;
  logic [dasp_pkg::VALUE_BITS-1:0] res_value;

  dasp_front u_front (
    .char_i  (s_axis_tdata_i[dasp_pkg::CHAR_BITS-1:0]),
    .eol_i   (s_axis_tlast_i),
    .token_o (in_token)
  );

  dasp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid_i),
    .push_token_i (in_token),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .token_o      (q_token),
    .pop_i        (q_pop)
  );

  assign s_axis_tready_o = !q_full;

  dasp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (q_valid),
    .token_i      (q_token),
    .tok_pop_o    (q_pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_value_o  (res_value),
    .res_status_o (m_axis_tuser_o),
    .res_ready_i  (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {{(dasp_pkg::OUT_DATA_BITS - dasp_pkg::VALUE_BITS){1'b0}}, res_value};

endmodule

`default_nettype wire
